FILE: rtl/core/bpsm_pkg.sv
// ----------------------------------------------------------------------------
// bpsm_pkg
// Shared widths, constants, codes and helpers for the Bernoulli / power sum
// block.
// ----------------------------------------------------------------------------
package bpsm_pkg;

  localparam int unsigned ValW     = 31;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned CountW   = 63;
  localparam int unsigned DepthDef = 256;

  localparam logic [ValW-1:0] ModReset = 31'd1000000007;

  localparam logic CmdBern = 1'b0;
  localparam logic CmdSum  = 1'b1;

  // request to and response from the serial modular multiplier
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [ValW-1:0] res;
  } mul_rsp_t;

  // a + b mod m for a, b < m
  function automatic logic [ValW-1:0] add_mod(logic [ValW-1:0] a, logic [ValW-1:0] b,
                                              logic [ValW-1:0] m);
    logic [ValW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[ValW-1:0];
  endfunction

endpackage

FILE: rtl/core/bernoulli_power_sum_mod_prime.sv
// ----------------------------------------------------------------------------
// bernoulli_power_sum_mod_prime
// Bernoulli numbers and Faulhaber power sums modulo a configured prime, with
// a lazily extended Bernoulli table and one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
// Timing: an out-of-range index or a modulus below 2 is answered directly;
//   otherwise the run time is set by the bit-serial multiplier, the Pascal
//   rows rebuilt (each entry read, then written), the bit-by-bit modular
//   reductions and the inverses (31 squarings plus up to 31 multiplies).
// Flow: one query at a time; a new one is taken when idle, also while a result waits.
// Reset: modulus 1000000007, table holds only B0 = 1; no clearing pass.
module bernoulli_power_sum_mod_prime
  import bpsm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ValW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [IdxW-1:0]   index_i,
  input  logic [CountW-1:0] count_n_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValW-1:0]   value_o,
  output logic              status_o
);

  localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW = $clog2(TABLE_DEPTH + 2);
  localparam int unsigned TW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = (FW > IdxW) ? FW : IdxW;
  localparam int unsigned PCW = $clog2(ValW);
  localparam int unsigned RCW = $clog2(CountW);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [30:0] {
    S_IDLE       = 31'h0000_0001,
    S_FILL_CHK   = 31'h0000_0002,
    S_PAS_CHK    = 31'h0000_0004,
    S_PAS_RD     = 31'h0000_0008,
    S_PAS_WR     = 31'h0000_0010,
    S_SUM_START  = 31'h0000_0020,
    S_SUM_RD     = 31'h0000_0040,
    S_SUM_MUL    = 31'h0000_0080,
    S_SUM_ACC    = 31'h0000_0100,
    S_RED_RUN    = 31'h0000_0200,
    S_FILL_POW   = 31'h0000_0400,
    S_POW_SQ     = 31'h0000_0800,
    S_POW_BIT    = 31'h0000_1000,
    S_POW_TAKE   = 31'h0000_2000,
    S_POW_NEXT   = 31'h0000_4000,
    S_FILL_SCALE = 31'h0000_8000,
    S_FILL_WR    = 31'h0001_0000,
    S_CMD0_RD    = 31'h0002_0000,
    S_CMD0_DAT   = 31'h0004_0000,
    S_C1_NM      = 31'h0008_0000,
    S_C1_START   = 31'h0010_0000,
    S_C1_RD      = 31'h0020_0000,
    S_C1_M1      = 31'h0040_0000,
    S_C1_M2      = 31'h0080_0000,
    S_C1_ACC     = 31'h0100_0000,
    S_C1_NEXT    = 31'h0200_0000,
    S_C1_POW     = 31'h0400_0000,
    S_C1_FIN     = 31'h0800_0000,
    S_C1_WR      = 31'h1000_0000,
    S_MUL_WAIT   = 31'h2000_0000,
    S_OUT        = 31'h4000_0000
  } state_e;

  state_e            state_q, state_d;
  state_e            sub_ret_q, sub_ret_d;
  state_e            mul_ret_q, mul_ret_d;
  logic              cmd_q, cmd_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CountW-1:0] n_q, n_d;
  logic [ValW-1:0]   mod_q, mod_d;
  logic [FW-1:0]     filled_q, filled_d;
  logic [RW-1:0]     rn_q, rn_d;
  logic [RW-1:0]     tgt_q, tgt_d;
  logic [RW-1:0]     j_q, j_d;
  logic [ValW-1:0]   prev_q, prev_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic [ValW-1:0]   p_q, p_d;
  logic [ValW-1:0]   nm_q, nm_d;
  logic [PCW-1:0]    pcnt_q, pcnt_d;
  logic [ValW-1:0]   pbase_q, pbase_d;
  logic [ValW-1:0]   pr_q, pr_d;
  logic [CountW-1:0] red_sr_q, red_sr_d;
  logic [ValW-1:0]   red_r_q, red_r_d;
  logic [RCW-1:0]    red_cnt_q, red_cnt_d;
  logic [ValW-1:0]   res_val_q, res_val_d;
  logic              res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  logic [ValW-1:0]   out_val_q, out_val_d;
  logic              out_st_q, out_st_d;

  logic [ValW-1:0] tbl_mem [TABLE_DEPTH];
  logic [ValW-1:0] row_mem [TABLE_DEPTH + 2];
  logic [ValW-1:0] tbl_rdata_q;
  logic [ValW-1:0] row_rdata_q;
  logic            tbl_we;
  logic [ValW-1:0] tbl_wdata;
  logic            row_we;
  logic [RW-1:0]   row_waddr;
  logic [ValW-1:0] row_wdata;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic            in_xfer;
  logic [RW-1:0]   nr;
  logic [ValW-1:0] old_v;
  logic [ValW-1:0] b_v;
  logic [ValW-1:0] pexp;
  logic [ValW:0]   red_t;
  logic [ValW-1:0] neg_v;

  bpsm_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign nr         = rn_q + RW'(1);
  assign old_v      = (j_q == nr) ? '0 : row_rdata_q;
  assign b_v        = (j_q == '0) ? ValW'(1) : tbl_rdata_q;
  assign pexp       = mod_q - ValW'(2);
  assign red_t      = {red_r_q, red_sr_q[CountW-1]};
  assign neg_v      = (mul_rsp.res == '0) ? '0 : mod_q - mul_rsp.res;

  always_comb begin
    state_d     = state_q;
    sub_ret_d   = sub_ret_q;
    mul_ret_d   = mul_ret_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    n_d         = n_q;
    mod_d       = mod_q;
    filled_d    = filled_q;
    rn_d        = rn_q;
    tgt_d       = tgt_q;
    j_d         = j_q;
    prev_d      = prev_q;
    acc_d       = acc_q;
    p_d         = p_q;
    nm_d        = nm_q;
    pcnt_d      = pcnt_q;
    pbase_d     = pbase_q;
    pr_d        = pr_q;
    red_sr_d    = red_sr_q;
    red_r_d     = red_r_q;
    red_cnt_d   = red_cnt_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_req     = '0;
    tbl_we      = 1'b0;
    tbl_wdata   = neg_v;
    row_we      = 1'b0;
    row_waddr   = j_q;
    row_wdata   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d = command_i;
          idx_d = index_i;
          n_d   = count_n_i;
          if (CW'(index_i) >= DepthC) begin
            res_val_d = '0;
            res_st_d  = 1'b1;
            state_d   = S_OUT;
          end else if (mod_q < ValW'(2)) begin
            res_val_d = '0;
            res_st_d  = 1'b0;
            state_d   = S_OUT;
          end else begin
            // restart the Pascal row at row 0
            rn_d      = '0;
            row_we    = 1'b1;
            row_waddr = '0;
            row_wdata = ValW'(1);
            res_st_d  = 1'b0;
            state_d   = S_FILL_CHK;
          end
        end
      end
      S_FILL_CHK: begin
        if (CW'(filled_q) <= CW'(idx_q)) begin
          tgt_d     = RW'(filled_q) + RW'(1);
          sub_ret_d = S_SUM_START;
          state_d   = S_PAS_CHK;
        end else if (cmd_q == CmdBern) begin
          j_d     = RW'(idx_q);
          state_d = S_CMD0_RD;
        end else begin
          red_sr_d  = n_q;
          red_r_d   = '0;
          red_cnt_d = RCW'(CountW - 1);
          sub_ret_d = S_C1_NM;
          state_d   = S_RED_RUN;
        end
      end
      S_PAS_CHK: begin
        if (rn_q == tgt_q) begin
          state_d = sub_ret_q;
        end else begin
          j_d     = '0;
          prev_d  = '0;
          state_d = S_PAS_RD;
        end
      end
      S_PAS_RD: state_d = S_PAS_WR;
      S_PAS_WR: begin
        row_we    = 1'b1;
        row_wdata = add_mod(old_v, prev_q, mod_q);
        prev_d    = old_v;
        if (j_q == nr) begin
          rn_d    = nr;
          state_d = S_PAS_CHK;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_PAS_RD;
        end
      end
      S_SUM_START: begin
        acc_d   = '0;
        j_d     = '0;
        state_d = S_SUM_RD;
      end
      S_SUM_RD: state_d = S_SUM_MUL;
      S_SUM_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = row_rdata_q;
        mul_req.b     = b_v;
        mul_ret_d     = S_SUM_ACC;
        state_d       = S_MUL_WAIT;
      end
      S_SUM_ACC: begin
        acc_d = add_mod(acc_q, mul_rsp.res, mod_q);
        if (j_q + RW'(1) == RW'(filled_q)) begin
          red_sr_d  = CountW'(filled_q) + CountW'(1);
          red_r_d   = '0;
          red_cnt_d = RCW'(CountW - 1);
          sub_ret_d = S_FILL_POW;
          state_d   = S_RED_RUN;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_SUM_RD;
        end
      end
      S_RED_RUN: begin
        red_r_d  = (red_t >= {1'b0, mod_q}) ? ValW'(red_t - {1'b0, mod_q}) : ValW'(red_t);
        red_sr_d = {red_sr_q[CountW-2:0], 1'b0};
        red_cnt_d = red_cnt_q - RCW'(1);
        if (red_cnt_q == '0) begin
          state_d = sub_ret_q;
        end
      end
      S_FILL_POW, S_C1_POW: begin
        pbase_d   = red_r_q;
        pr_d      = ValW'(1);
        pcnt_d    = PCW'(ValW - 1);
        sub_ret_d = (state_q == S_FILL_POW) ? S_FILL_SCALE : S_C1_FIN;
        state_d   = S_POW_SQ;
      end
      S_POW_SQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = pr_q;
        mul_req.b     = pr_q;
        mul_ret_d     = S_POW_BIT;
        state_d       = S_MUL_WAIT;
      end
      S_POW_BIT: begin
        pr_d = mul_rsp.res;
        if (pexp[pcnt_q]) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.res;
          mul_req.b     = pbase_q;
          mul_ret_d     = S_POW_TAKE;
          state_d       = S_MUL_WAIT;
        end else begin
          state_d = S_POW_NEXT;
        end
      end
      S_POW_TAKE: begin
        pr_d    = mul_rsp.res;
        state_d = S_POW_NEXT;
      end
      S_POW_NEXT: begin
        if (pcnt_q == '0) begin
          state_d = sub_ret_q;
        end else begin
          pcnt_d  = pcnt_q - PCW'(1);
          state_d = S_POW_SQ;
        end
      end
      S_FILL_SCALE: begin
        mul_req.start = 1'b1;
        mul_req.a     = acc_q;
        mul_req.b     = pr_q;
        mul_ret_d     = S_FILL_WR;
        state_d       = S_MUL_WAIT;
      end
      S_FILL_WR: begin
        tbl_we   = 1'b1;
        filled_d = filled_q + FW'(1);
        state_d  = S_FILL_CHK;
      end
      S_CMD0_RD: state_d = S_CMD0_DAT;
      S_CMD0_DAT: begin
        res_val_d = b_v;
        state_d   = S_OUT;
      end
      S_C1_NM: begin
        nm_d      = red_r_q;
        p_d       = red_r_q;
        tgt_d     = RW'(idx_q) + RW'(1);
        sub_ret_d = S_C1_START;
        state_d   = S_PAS_CHK;
      end
      S_C1_START: begin
        acc_d   = '0;
        j_d     = RW'(idx_q);
        state_d = S_C1_RD;
      end
      S_C1_RD: state_d = S_C1_M1;
      S_C1_M1: begin
        mul_req.start = 1'b1;
        mul_req.a     = row_rdata_q;
        mul_req.b     = b_v;
        mul_ret_d     = S_C1_M2;
        state_d       = S_MUL_WAIT;
      end
      S_C1_M2: begin
        mul_req.start = 1'b1;
        mul_req.a     = mul_rsp.res;
        mul_req.b     = p_q;
        mul_ret_d     = S_C1_ACC;
        state_d       = S_MUL_WAIT;
      end
      S_C1_ACC: begin
        // p steps to the next power as j walks down
        acc_d         = add_mod(acc_q, mul_rsp.res, mod_q);
        mul_req.start = 1'b1;
        mul_req.a     = p_q;
        mul_req.b     = nm_q;
        mul_ret_d     = S_C1_NEXT;
        state_d       = S_MUL_WAIT;
      end
      S_C1_NEXT: begin
        p_d = mul_rsp.res;
        if (j_q == '0) begin
          red_sr_d  = CountW'(idx_q) + CountW'(1);
          red_r_d   = '0;
          red_cnt_d = RCW'(CountW - 1);
          sub_ret_d = S_C1_POW;
          state_d   = S_RED_RUN;
        end else begin
          j_d     = j_q - RW'(1);
          state_d = S_C1_RD;
        end
      end
      S_C1_FIN: begin
        mul_req.start = 1'b1;
        mul_req.a     = acc_q;
        mul_req.b     = pr_q;
        mul_ret_d     = S_C1_WR;
        state_d       = S_MUL_WAIT;
      end
      S_C1_WR: begin
        res_val_d = mul_rsp.res;
        state_d   = S_OUT;
      end
      S_MUL_WAIT: begin
        if (mul_rsp.done) begin
          state_d = mul_ret_q;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      mod_d    = cfg_wdata_i;
      filled_d = FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sub_ret_q   <= S_IDLE;
      mul_ret_q   <= S_IDLE;
      mod_q       <= ModReset;
      filled_q    <= FW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sub_ret_q   <= sub_ret_d;
      mul_ret_q   <= mul_ret_d;
      mod_q       <= mod_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    n_q       <= n_d;
    rn_q      <= rn_d;
    tgt_q     <= tgt_d;
    j_q       <= j_d;
    prev_q    <= prev_d;
    acc_q     <= acc_d;
    p_q       <= p_d;
    nm_q      <= nm_d;
    pcnt_q    <= pcnt_d;
    pbase_q   <= pbase_d;
    pr_q      <= pr_d;
    red_sr_q  <= red_sr_d;
    red_r_q   <= red_r_d;
    red_cnt_q <= red_cnt_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[filled_q[TW-1:0]] <= tbl_wdata;
    end
    tbl_rdata_q <= tbl_mem[j_q[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rdata_q <= row_mem[j_q];
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign status_o    = out_st_q;

  a_filled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q != '0) && (CW'(filled_q) <= DepthC))
    else $error("table fill count out of range");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> value_o == '0)
    else $error("out-of-range status with nonzero value");

  a_value_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o && (mod_q >= ValW'(2)) |-> value_o < mod_q)
    else $error("result not reduced");

  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |=> state_q == S_MUL_WAIT)
    else $error("multiplier started outside a wait");

endmodule

FILE: rtl/core/bpsm_mulmod.sv
// ----------------------------------------------------------------------------
// bpsm_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first,
// doubling and adding, with a conditional subtract after each, at every step.
// ----------------------------------------------------------------------------
module bpsm_mulmod
  import bpsm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ValW-1:0] mod_i,
  input  mul_req_t        req_i,
  output mul_rsp_t        rsp_o
);

  localparam int unsigned CntW = $clog2(ValW);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0] a_q, a_d;
  logic [ValW-1:0] b_q, b_d;
  logic [ValW-1:0] r_q, r_d;
  logic [ValW:0]   dbl;
  logic [ValW:0]   dbl_red;
  logic [ValW:0]   sum;
  logic [ValW:0]   sum_red;

  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, mod_i}) ? dbl - {1'b0, mod_i} : dbl;
    sum     = dbl_red + (b_q[ValW-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= {1'b0, mod_i}) ? sum - {1'b0, mod_i} : sum;
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = CntW'(ValW - 1);
      a_d   = req_i.a;
      b_d   = req_i.b;
      r_d   = '0;
    end else if (run_q) begin
      r_d = sum_red[ValW-1:0];
      b_d = {b_q[ValW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    b_q   <= b_d;
    r_q   <= r_d;
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = r_q;

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks Bernoulli number and power sum queries against an internal predictor.
// The predictor keeps its own lazily filled table and modulus. Queries are
// driven with random stalls and gaps, and the modulus is changed between
// phases.
// ----------------------------------------------------------------------------
module testbench;
  import bpsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = DepthDef;

  typedef struct {
    logic              cmd;
    logic [IdxW-1:0]   idx;
    logic [CountW-1:0] n;
  } query_t;

  typedef struct {
    logic [ValW-1:0] value;
    logic            status;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ValW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              command_i = CmdBern;
  logic [IdxW-1:0]   index_i = '0;
  logic [CountW-1:0] count_n_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ValW-1:0]   value_o;
  logic              status_o;

  bernoulli_power_sum_mod_prime u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .index_i     (index_i),
    .count_n_i   (count_n_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [63:0]     mod_cur;
  logic [ValW-1:0] bern_tab[Depth];
  int unsigned     bern_filled;

  query_t  query_q[$];
  answer_t answer_q[$];
  int      n_driven = 0;
  int      n_taken = 0;
  int      n_checked = 0;
  int      n_errors = 0;
  int      n_sums = 0;
  bit      idle_on = 1'b1;
  bit      hold_tx = 1'b0;
  bit      started = 1'b0;
  int      tx_gap = 0;
  int      rx_gap = 0;

  function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a * b) % m;
  endfunction

  function automatic logic [63:0] pow_m(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_m(r, b, m);
      b = mul_m(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic void reset_table();
    foreach (bern_tab[i]) bern_tab[i] = '0;
    bern_tab[0] = 1;
    bern_filled = 1;
  endfunction

  // advance a Pascal row to row number target
  function automatic void pascal_step(ref logic [63:0] row[Depth+2], ref int unsigned rn,
                                      input int unsigned target, input logic [63:0] m);
    while (rn < target) begin
      row[rn+1] = 0;
      for (int j = rn + 1; j >= 1; j--) row[j] = (row[j] + row[j-1]) % m;
      rn++;
    end
  endfunction

  function automatic void extend_table(int unsigned idx, logic [63:0] m);
    logic [63:0] row[Depth+2];
    int unsigned rn;
    logic [63:0] acc;
    int unsigned k;
    rn = 0;
    row[0] = 1 % m;
    while (bern_filled <= idx && bern_filled < Depth) begin
      k = bern_filled;
      acc = 0;
      pascal_step(row, rn, k + 1, m);
      for (int j = 0; j < k; j++) acc = (acc + mul_m(row[j], bern_tab[j], m)) % m;
      acc = mul_m(acc, pow_m(k + 1, m - 2, m), m);
      acc = (acc == 0) ? 0 : m - acc;
      bern_tab[k] = acc[ValW-1:0];
      bern_filled = k + 1;
    end
  endfunction

  function automatic answer_t compute_answer(query_t q);
    answer_t a;
    logic [63:0] m;
    logic [63:0] row[Depth+2];
    int unsigned rn;
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] nm;
    m = mod_cur;
    a.value = '0;
    a.status = 1'b0;
    if (q.idx >= Depth) begin
      a.status = 1'b1;
    end else if (m >= 2) begin
      extend_table(q.idx, m);
      if (q.cmd == CmdBern) begin
        a.value = bern_tab[q.idx] % m;
      end else begin
        rn = 0;
        row[0] = 1 % m;
        acc = 0;
        nm = {1'b0, q.n} % m;
        pascal_step(row, rn, q.idx + 1, m);
        for (int j = 0; j <= q.idx; j++) begin
          t = mul_m(row[j], bern_tab[j] % m, m);
          t = mul_m(t, pow_m(nm, q.idx - j + 1, m), m);
          acc = (acc + t) % m;
        end
        acc = mul_m(acc, pow_m(q.idx + 1, m - 2, m), m);
        a.value = acc[ValW-1:0];
      end
    end
    return a;
  endfunction

  // input side: capture transfers and predict
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      query_t q;
      q.cmd = command_i;
      q.idx = index_i;
      q.n = count_n_i;
      answer_q.insert(answer_q.size(), compute_answer(q));
      if (q.cmd == CmdSum) n_sums++;
      n_taken++;
    end
  end

  // driver: present the next query once the previous one has transferred
  always @(negedge clk_i) begin
    if (started && n_driven == n_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (query_q.size() > 0 && !hold_tx) begin
        query_t q;
        q = query_q.pop_front();
        command_i <= q.cmd;
        index_i <= q.idx;
        count_n_i <= q.n;
        in_valid_i <= 1'b1;
        n_driven++;
        if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 19);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (rx_gap > 0) begin
      rx_gap--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      answer_t a;
      if (answer_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result value=%0d status=%0d",
                                     value_o, status_o);
      end else begin
        a = answer_q.pop_front();
        n_checked++;
        if (a.value !== value_o || a.status !== status_o) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d expected value=%0d status=%0d, got value=%0d status=%0d",
                     n_checked, a.value, a.status, value_o, status_o);
        end
      end
    end
  end

  function automatic void add_query(logic cmd, logic [IdxW-1:0] idx, logic [CountW-1:0] n);
    query_t q;
    q.cmd = cmd;
    q.idx = idx;
    q.n = n;
    query_q.insert(query_q.size(), q);
  endfunction

  function automatic logic [CountW-1:0] rand_count();
    case ($urandom_range(0, 3))
      0: return CountW'($urandom_range(0, 40));
      1: return CountW'({$urandom, $urandom});
      2: return CountW'(mod_cur + $urandom_range(0, 3) - 2);
      default: return CountW'($urandom);
    endcase
  endfunction

  function automatic void add_random(int cnt);
    for (int i = 0; i < cnt; i++) begin
      // keep most exponents small, a full-depth query is slow
      add_query(1'($urandom_range(0, 1)),
                IdxW'(($urandom_range(0, 24) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 24)),
                rand_count());
    end
  endfunction

  task automatic wait_drained();
    wait (query_q.size() == 0 && n_driven == n_taken && answer_q.size() == 0);
  endtask

  task automatic write_modulus(logic [ValW-1:0] m);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mod_cur = m;
    reset_table();
  endtask

  initial begin
    mod_cur = ModReset;
    reset_table();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    started = 1'b1;

    add_query(CmdBern, 0, 0);
    add_query(CmdBern, 1, 0);
    add_query(CmdBern, 2, 5);
    add_query(CmdBern, 3, 5);
    add_query(CmdSum, 0, 0);
    add_query(CmdSum, 0, 1);
    add_query(CmdSum, 1, 10);
    add_query(CmdSum, 2, '1);
    add_query(CmdSum, 5, 0);
    add_query(CmdSum, 3, ModReset);
    add_query(CmdSum, 4, ModReset - 1);
    add_query(CmdBern, 128, '1);
    add_query(CmdBern, 255, 0);
    add_query(CmdSum, 255, 63'h5555_5555_5555_5555);
    add_query(CmdSum, 170, 63'h2AAA_AAAA_AAAA_AAAA);
    add_query(CmdBern, 7, 0);
    add_random(10);
    // hold the sender until everything in flight has come back
    wait (query_q.size() <= 5);
    hold_tx = 1'b1;
    wait (n_driven == n_taken && answer_q.size() == 0);
    hold_tx = 1'b0;

    write_modulus(31'd263);
    add_query(CmdBern, 255, 0);
    add_query(CmdSum, 254, 263);
    add_random(35);
    write_modulus(31'd2147483647);
    add_query(CmdSum, 20, '1);
    add_random(35);
    write_modulus(31'd998244353);
    add_random(25);
    write_modulus(ModReset);
    wait_drained();
    idle_on = 1'b0;
    add_random(20);
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("Checked %0d results (%0d power sums) over four moduli, %0d mismatches.",
             n_checked, n_sums, n_errors);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000_000;
    $display("Timeout with %0d results outstanding.", answer_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bpsm_pkg.sv
rtl/core/bpsm_mulmod.sv
rtl/core/bernoulli_power_sum_mod_prime.sv
verif/testbench.sv
